// File: hw/rtl/urdc_pkg.sv
// Shared types and constants for the unsigned radix digit converter.
// No dependencies; used by urdc_div and unsigned_radix_digit_converter_core.
package urdc_pkg;

  localparam int VALUE_W = 64;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int CNT_W   = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;  // 'A'

  // One input item
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } in_t;

  // One result item (one digit, or one error marker)
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic [CNT_W-1:0]  digit_count;
    logic              last_digit;
    logic              radix_error;
  } out_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] remainder;
  } div_rsp_t;

  // Digit value (0..35) to ASCII
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d7;
    d7 = CHAR_W'(d);
    if (d < DEC_BASE) begin
      return d7 + ASCII_ZERO;
    end
    return d7 - CHAR_W'(DEC_BASE) + ASCII_A;
  endfunction

endpackage

// File: hw/rtl/urdc_div.sv
// Bit-serial restoring divider: 64-bit dividend by a 6-bit divisor.
// Depends on urdc_pkg for widths and the request/response structs.
module urdc_div (
  input  logic               clk,
  input  logic               rst,
  input  urdc_pkg::div_req_t req,
  output urdc_pkg::div_rsp_t rsp
);

  localparam int VW = urdc_pkg::VALUE_W;
  localparam int RW = urdc_pkg::RADIX_W;
  localparam int SW = $clog2(VW);

  logic          busy;
  logic          done;
  logic [SW-1:0] step;
  logic [VW-1:0] quo;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_next;
  logic [VW-1:0] quo_next;

  // One quotient bit per cycle, MSB first
  always_comb begin
    trial    = {rem, quo[VW-1]};
    ge       = (trial >= {1'b0, dvs});
    diff     = trial - {1'b0, dvs};
    rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
    quo_next = {quo[VW-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(VW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

`ifndef ASSERT_OFF
  // A new division never starts over one in flight
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");
`endif

endmodule

// File: hw/rtl/unsigned_radix_digit_converter_core.sv
// Top level of the unsigned radix digit converter: FSM, digit store, output register.
// Depends on urdc_pkg and urdc_div.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes a 64-bit value and a radix.
//   digit channel (digit_valid/digit_ready/digit) returns the ASCII digits, most
//   significant first, each with the total digit count; last_digit marks the end.
//   A radix outside 2..36 gives one result with radix_error and last_digit set.
// Flow:
//   Each digit costs one pass of the bit-serial divider; the remainder is
//   written into the digit store when the divider reports done. Emission reads
//   each digit from the store (S_RD), then loads it into the output register
//   (S_EMIT). The next item can transfer once the last digit has been loaded.
//   One item is in work at a time; item_ready is high whenever the block is idle,
//   even while the last result still waits in the output register.
// Reset: the FSM returns to idle and the output register empties. The digit store
//   needs no clearing since every conversion writes each entry before reading it.
// Stalls: a low digit_ready holds the current result; the FSM waits with it.
module unsigned_radix_digit_converter_core #(
  parameter int MAX_DIGITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  urdc_pkg::in_t  item,
  output logic           digit_valid,
  input  logic           digit_ready,
  output urdc_pkg::out_t digit
);

  localparam int RW = urdc_pkg::RADIX_W;
  localparam int CW = urdc_pkg::CNT_W;
  localparam int AW = $clog2(MAX_DIGITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ERR  = 5'b00010,
    S_DIV  = 5'b00100,
    S_RD   = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_next;
  logic [RW-1:0]  radix_q;
  logic [AW-1:0]  rd_idx;
  logic [RW-1:0]  rd_data;
  logic [RW-1:0]  store [MAX_DIGITS];

  urdc_pkg::div_req_t div_req;
  urdc_pkg::div_rsp_t div_rsp;

  logic item_xfer;
  logic radix_ok;
  logic out_free;
  logic more;

  assign item_ready = (state == S_IDLE);
  assign item_xfer  = item_valid && item_ready;
  assign radix_ok   = (item.radix >= urdc_pkg::RADIX_MIN) &&
                      (item.radix <= urdc_pkg::RADIX_MAX);
  assign out_free   = !digit_valid || digit_ready;
  assign cnt_next   = cnt + CW'(1);
  assign more       = (div_rsp.quotient != '0) && (cnt_next < CW'(MAX_DIGITS));

  urdc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Divider kick: first digit on a legal transfer, further ones while more are needed
  always_comb begin
    div_req.start    = (item_xfer && radix_ok) ||
                       (state == S_DIV && div_rsp.done && more);
    div_req.dividend = (state == S_IDLE) ? item.value : div_rsp.quotient;
    div_req.divisor  = (state == S_IDLE) ? item.radix : radix_q;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_xfer) state_next = radix_ok ? S_DIV : S_ERR;
      end
      S_ERR: begin
        if (out_free) state_next = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done && !more) state_next = S_RD;
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = (rd_idx == '0) ? S_IDLE : S_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Conversion state: digit count, read pointer, radix
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
    end else begin
      if (item_xfer && radix_ok) begin
        cnt     <= '0;
        radix_q <= item.radix;
      end else if (state == S_DIV && div_rsp.done) begin
        cnt    <= cnt_next;
        rd_idx <= cnt[AW-1:0];
      end else if (state == S_EMIT && out_free) begin
        rd_idx <= rd_idx - AW'(1);
      end
    end
  end

  // Digit store: remainders written in order, read back in reverse.
  // Write and read phases never overlap, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done) begin
      store[cnt[AW-1:0]] <= div_rsp.remainder;
    end
    if (state == S_RD) begin
      rd_data <= store[rd_idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (state == S_ERR && out_free) begin
      digit_valid <= 1'b1;
    end else if (state == S_EMIT && out_free) begin
      digit_valid <= 1'b1;
    end else if (digit_ready) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ERR && out_free) begin
      digit.digit_char  <= '0;
      digit.digit_count <= '0;
      digit.last_digit  <= 1'b1;
      digit.radix_error <= 1'b1;
    end else if (state == S_EMIT && out_free) begin
      digit.digit_char  <= urdc_pkg::ascii_of(rd_data);
      digit.digit_count <= cnt;
      digit.last_digit  <= (rd_idx == '0);
      digit.radix_error <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // Division only runs while the store still has room
  a_store_room: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < CW'(MAX_DIGITS))
    else $error("division with a full digit store");

  // Divider results arrive only while the FSM waits for them
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider result outside division phase");

  // Remainder always fits below the radix
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> div_rsp.remainder < radix_q)
    else $error("remainder not below radix");

  // Read pointer stays inside the written part of the store
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> CW'(rd_idx) < cnt)
    else $error("digit read beyond written entries");
`endif

endmodule

// File: test/urdc_digit_checker.sv
// Checker for the unsigned radix digit converter: watches both channels,
// works out the expected digits of each accepted item and compares them.
// Depends on urdc_pkg.
module urdc_digit_checker #(
  parameter int MAX_DIGITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_ready,
  input  urdc_pkg::in_t  item,
  input  logic           digit_valid,
  input  logic           digit_ready,
  input  urdc_pkg::out_t digit,
  output int             fail_count,
  output int             pending
);

  urdc_pkg::out_t expected_digits[$];
  int             fails = 0;

  // Glyph for one digit value: '0'..'9', then 'A'..'Z'
  function automatic logic [urdc_pkg::CHAR_W-1:0] glyph(
    input logic [urdc_pkg::RADIX_W-1:0] d
  );
    logic [urdc_pkg::CHAR_W-1:0] wide;
    wide = {1'b0, d};
    if (d < 6'd10) begin
      return urdc_pkg::ASCII_ZERO + wide;
    end
    return urdc_pkg::ASCII_A + (wide - 7'd10);
  endfunction

  // Convert one item and queue its digits, most significant first
  function automatic void predict_digits(input urdc_pkg::in_t it);
    logic [urdc_pkg::VALUE_W-1:0] quot;
    logic [urdc_pkg::VALUE_W-1:0] base;
    logic [urdc_pkg::RADIX_W-1:0] rems[MAX_DIGITS];
    int                           n;
    urdc_pkg::out_t               res;
    if (it.radix < urdc_pkg::RADIX_MIN || it.radix > urdc_pkg::RADIX_MAX) begin
      res.digit_char  = '0;
      res.digit_count = '0;
      res.last_digit  = 1'b1;
      res.radix_error = 1'b1;
      expected_digits.push_back(res);
      return;
    end
    base = {{(urdc_pkg::VALUE_W-urdc_pkg::RADIX_W){1'b0}}, it.radix};
    quot = it.value;
    n    = 0;
    // Zero still yields one digit, so test after the first division
    do begin
      rems[n] = urdc_pkg::RADIX_W'(quot % base);
      n++;
      quot = quot / base;
    end while (quot != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      res.digit_char  = glyph(rems[k]);
      res.digit_count = urdc_pkg::CNT_W'(n);
      res.last_digit  = (k == 0);
      res.radix_error = 1'b0;
      expected_digits.push_back(res);
    end
  endfunction

  // Predict on item transfers, compare on digit transfers
  always @(posedge clk) begin
    urdc_pkg::out_t want;
    bit             bad;
    if (rst) begin
      expected_digits.delete();
      pending    <= 0;
      fail_count <= fails;
    end else begin
      if (item_valid && item_ready) begin
        predict_digits(item);
      end
      if (digit_valid && digit_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: digit transfer with nothing expected, actual char %0d count %0d",
                   $time, digit.digit_char, digit.digit_count);
          fails++;
        end else begin
          want = expected_digits.pop_front();
          bad  = 1'b0;
          if (digit.digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %0d, actual %0d",
                     $time, want.digit_char, digit.digit_char);
            bad = 1'b1;
          end
          if (digit.digit_count !== want.digit_count) begin
            $display("%0t: digit_count expected %0d, actual %0d",
                     $time, want.digit_count, digit.digit_count);
            bad = 1'b1;
          end
          if (digit.last_digit !== want.last_digit) begin
            $display("%0t: last_digit expected %0b, actual %0b",
                     $time, want.last_digit, digit.last_digit);
            bad = 1'b1;
          end
          if (digit.radix_error !== want.radix_error) begin
            $display("%0t: radix_error expected %0b, actual %0b",
                     $time, want.radix_error, digit.radix_error);
            bad = 1'b1;
          end
          if (bad) begin
            fails++;
          end
        end
      end
      pending    <= expected_digits.size();
      fail_count <= fails;
    end
  end

endmodule

// File: test/tb_unsigned_radix_digit_converter_core.sv
// Testbench top for unsigned_radix_digit_converter_core: directed and random
// conversions with random stalls on both channels; verdict from urdc_digit_checker.
// Depends on urdc_pkg, the converter RTL and urdc_digit_checker.
module tb_unsigned_radix_digit_converter_core;

  localparam int MAX_DIGITS  = 64;
  localparam int RANDOM_ITEMS = 120;
  localparam int CALM_ITEMS  = 20;
  // A full 64-digit binary conversion moves nothing while its divisions run
  localparam int STALL_LIMIT = 20000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           item_valid = 1'b0;
  logic           item_ready;
  urdc_pkg::in_t  item = '0;
  logic           digit_valid;
  logic           digit_ready = 1'b0;
  urdc_pkg::out_t digit;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  unsigned_radix_digit_converter_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .digit_valid(digit_valid),
    .digit_ready(digit_ready),
    .digit      (digit)
  );

  urdc_digit_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .digit_valid(digit_valid),
    .digit_ready(digit_ready),
    .digit      (digit),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (digit_valid && digit_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts between ready stretches, none once calm
  initial begin
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        digit_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        digit_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Present one item and hold it until the transfer
  task automatic send_item(input urdc_pkg::in_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Hold off until every expected digit has come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly short values and legal radixes; a few wide values, zeros and bad radixes
  function automatic urdc_pkg::in_t rand_item();
    urdc_pkg::in_t it;
    int            pick;
    int            bits;
    int            r;
    pick = $urandom_range(0, 9);
    bits = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 64) : $urandom_range(1, 40);
    it.value = {$urandom, $urandom};
    if (bits < 64) begin
      it.value = it.value & ((64'd1 << bits) - 64'd1);
    end
    if (pick == 1) begin
      it.value = '0;
    end
    if (pick == 0) begin
      r = $urandom_range(0, 28);
      it.radix = urdc_pkg::RADIX_W'((r < 2) ? r : r + 35);
    end else begin
      it.radix = urdc_pkg::RADIX_W'($urandom_range(2, 36));
    end
    return it;
  endfunction

  initial begin
    urdc_pkg::in_t directed[$];
    directed.push_back('{value: 64'd0, radix: 6'd10});
    directed.push_back('{value: 64'd0, radix: 6'd2});
    directed.push_back('{value: 64'd0, radix: 6'd36});
    directed.push_back('{value: '1, radix: 6'd2});
    directed.push_back('{value: '1, radix: 6'd36});
    directed.push_back('{value: '1, radix: 6'd10});
    directed.push_back('{value: '1, radix: 6'd16});
    directed.push_back('{value: 64'h8000_0000_0000_0000, radix: 6'd2});
    directed.push_back('{value: 64'd1, radix: 6'd2});
    directed.push_back('{value: 64'd35, radix: 6'd36});
    directed.push_back('{value: 64'd36, radix: 6'd36});
    directed.push_back('{value: 64'd10, radix: 6'd16});
    directed.push_back('{value: 64'd9, radix: 6'd10});
    directed.push_back('{value: 64'h0123_4567_89AB_CDEF, radix: 6'd16});
    directed.push_back('{value: 64'd255, radix: 6'd3});
    directed.push_back('{value: 64'd1295, radix: 6'd36});
    // Bad radixes at both ends of the illegal ranges
    directed.push_back('{value: 64'd12345, radix: 6'd0});
    directed.push_back('{value: '1, radix: 6'd1});
    directed.push_back('{value: 64'd0, radix: 6'd37});
    directed.push_back('{value: 64'h5A5A_A5A5_0F0F_F0F0, radix: 6'd63});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i]);
      maybe_gap();
    end
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        drain();
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      send_item(rand_item());
      maybe_gap();
    end
    drain();

    // Room for any stray digits after the last expected one
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
